// ----- design/nrb_pkg.sv -----
// Shared types and constants for the planar rigid body Newmark integrator.
`default_nettype none
package nrb_pkg;
	localparam int DIV_STEPS = 48;

	typedef logic signed [31:0] q16_t;
	typedef logic signed [26:0] coef_t;

	typedef struct packed {
		logic [23:0] dt;
		coef_t       kq;
		coef_t       kb;
		coef_t       kv;
		coef_t       kg;
	} coef_set_t;

	typedef struct packed {
		logic done;
		logic sat;
	} lane_stat_t;

	localparam logic [2:0] MODE_FORCE    = 3'd0;
	localparam logic [2:0] MODE_ACCEL    = 3'd1;
	localparam logic [2:0] MODE_LOAD_POS = 3'd2;
	localparam logic [2:0] MODE_LOAD_VEL = 3'd3;
	localparam logic [2:0] MODE_LOAD_ACC = 3'd4;

	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_INVALID = 2'd1;
	localparam logic [1:0] STATUS_SAT     = 2'd2;

	localparam logic [2:0] REG_TIME_STEP    = 3'd0;
	localparam logic [2:0] REG_BETA_COEFF   = 3'd1;
	localparam logic [2:0] REG_GAMMA_COEFF  = 3'd2;
	localparam logic [2:0] REG_BODY_MASS    = 3'd3;
	localparam logic [2:0] REG_BODY_INERTIA = 3'd4;

	typedef enum logic [2:0] {
		ST_IDLE, ST_COEF1, ST_COEF2, ST_COEF3, ST_RUN, ST_FIN
	} seq_state_t;

	typedef enum logic [2:0] {
		LN_IDLE, LN_DIV, LN_DVF, LN_MUL, LN_SUM, LN_FIN
	} lane_state_t;
endpackage
`default_nettype wire

// ----- design/nrb_in_if.sv -----
// Input channel: mode and three values per transfer.
`default_nettype none
interface nrb_in_if;
	logic              valid;
	logic              ready;
	logic [2:0]        mode;
	logic signed [31:0] value_x;
	logic signed [31:0] value_y;
	logic signed [31:0] value_rot;
	modport source (output valid, mode, value_x, value_y, value_rot, input ready);
	modport sink (input valid, mode, value_x, value_y, value_rot, output ready);
endinterface
`default_nettype wire

// ----- design/nrb_out_if.sv -----
// Result channel: the nine stores and a status code per transfer.
`default_nettype none
interface nrb_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] position_x;
	logic signed [31:0] position_y;
	logic signed [31:0] angle;
	logic signed [31:0] velocity_x;
	logic signed [31:0] velocity_y;
	logic signed [31:0] angular_rate;
	logic signed [31:0] accel_x;
	logic signed [31:0] accel_y;
	logic signed [31:0] angular_accel;
	logic [1:0]         status;
	modport source (output valid, position_x, position_y, angle, velocity_x, velocity_y,
		angular_rate, accel_x, accel_y, angular_accel, status, input ready);
	modport sink (input valid, position_x, position_y, angle, velocity_x, velocity_y,
		angular_rate, accel_x, accel_y, angular_accel, status, output ready);
endinterface
`default_nettype wire

// ----- design/nrb_lane.sv -----
// One degree of freedom: force divider and Newmark predict/correct update.
`default_nettype none
module nrb_lane (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic                use_div,
	input  wire nrb_pkg::coef_set_t  coef,
	input  wire logic [31:0]         den,
	input  wire nrb_pkg::q16_t       value,
	input  wire nrb_pkg::q16_t       q,
	input  wire nrb_pkg::q16_t       v,
	input  wire nrb_pkg::q16_t       a,
	output nrb_pkg::lane_stat_t      stat,
	output nrb_pkg::q16_t            q_new,
	output nrb_pkg::q16_t            v_new,
	output nrb_pkg::q16_t            a_new
);
	nrb_pkg::lane_state_t state_q, state_d;
	logic [31:0] rem_q;
	logic [47:0] dvd_q;
	logic [47:0] quo_q;
	logic [5:0]  cnt_q;
	logic        neg_q;
	logic        sat_div_q;
	nrb_pkg::q16_t an_q;
	logic signed [58:0] pdv_s1, pkqa_s1, pkba_s1, pkva_s1, pkga_s1;
	logic signed [63:0] qs_s2, vs_s2;
	logic [32:0] rem_sh;
	logic        take;
	logic [31:0] mag;
	logic signed [24:0] dt_s;
	logic        sat_q_res, sat_v_res;

	// Truncate Q24.40 toward zero to Q16.16 and clamp; the top bit flags saturation.
	function automatic logic [32:0] trunc_clamp(input logic signed [63:0] s);
		logic signed [63:0] adj;
		logic signed [63:0] t;
		adj = s + (s[63] ? 64'sd16777215 : 64'sd0);
		t = adj >>> 24;
		if (t > 64'sd2147483647) return {1'b1, 32'h7FFFFFFF};
		if (t < -64'sd2147483648) return {1'b1, 32'h80000000};
		return {1'b0, t[31:0]};
	endfunction

	assign mag = value[31] ? (32'd0 - value) : value;
	assign rem_sh = {rem_q, dvd_q[47]};
	assign take = rem_sh >= {1'b0, den};
	assign dt_s = $signed({1'b0, coef.dt});

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			nrb_pkg::LN_IDLE: if (start) state_d = use_div ? nrb_pkg::LN_DIV : nrb_pkg::LN_MUL;
			nrb_pkg::LN_DIV:  if (cnt_q == 6'(nrb_pkg::DIV_STEPS - 1)) state_d = nrb_pkg::LN_DVF;
			nrb_pkg::LN_DVF:  state_d = nrb_pkg::LN_MUL;
			nrb_pkg::LN_MUL:  state_d = nrb_pkg::LN_SUM;
			nrb_pkg::LN_SUM:  state_d = nrb_pkg::LN_FIN;
			nrb_pkg::LN_FIN:  state_d = nrb_pkg::LN_IDLE;
			default:          state_d = nrb_pkg::LN_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= nrb_pkg::LN_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			nrb_pkg::LN_IDLE: begin
				an_q      <= value;
				neg_q     <= value[31];
				dvd_q     <= {mag, 16'b0};
				rem_q     <= '0;
				quo_q     <= '0;
				cnt_q     <= '0;
				sat_div_q <= 1'b0;
			end
			nrb_pkg::LN_DIV: begin
				// The partial remainder stays below the divisor, so 32 bits hold it.
				rem_q <= take ? 32'(rem_sh - {1'b0, den}) : rem_sh[31:0];
				quo_q <= {quo_q[46:0], take};
				dvd_q <= {dvd_q[46:0], 1'b0};
				cnt_q <= cnt_q + 6'd1;
			end
			nrb_pkg::LN_DVF: begin
				// A negative quotient is limited to the most negative value without a flag.
				if (quo_q >= 48'h80000000) begin
					an_q      <= neg_q ? 32'sh80000000 : 32'sh7FFFFFFF;
					sat_div_q <= !neg_q;
				end else begin
					an_q <= neg_q ? (32'sd0 - $signed(quo_q[31:0])) : $signed(quo_q[31:0]);
				end
			end
			nrb_pkg::LN_MUL: begin
				pdv_s1  <= 59'(dt_s * v);
				pkqa_s1 <= 59'(coef.kq * a);
				pkba_s1 <= 59'(coef.kb * an_q);
				pkva_s1 <= 59'(coef.kv * a);
				pkga_s1 <= 59'(coef.kg * an_q);
			end
			nrb_pkg::LN_SUM: begin
				qs_s2 <= $signed({{8{q[31]}}, q, 24'b0}) + 64'(pdv_s1) + 64'(pkqa_s1)
					+ 64'(pkba_s1);
				vs_s2 <= $signed({{8{v[31]}}, v, 24'b0}) + 64'(pkva_s1) + 64'(pkga_s1);
			end
			default: begin
			end
		endcase
	end

	assign {sat_q_res, q_new} = trunc_clamp(qs_s2);
	assign {sat_v_res, v_new} = trunc_clamp(vs_s2);
	assign a_new = an_q;
	assign stat.done = state_q == nrb_pkg::LN_FIN;
	assign stat.sat = sat_q_res | sat_v_res | sat_div_q;
endmodule
`default_nettype wire

// ----- design/newmark_rigid_body_2d_step.sv -----
// Top level: configuration, state stores, coefficient sequencer and three lanes.
// Loads, unused modes and invalid configurations go from idle straight to the finish
// state; acceleration steps pass the three coefficient states and the lane multiply and
// sum states, and force steps first run the one-bit-per-cycle divider in each lane.
// One item at a time: a new input waits until the last result enters the free result register.
// Asynchronous active-low reset clears the stores to zero and the registers to defaults.
`default_nettype none
module newmark_rigid_body_2d_step (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	nrb_in_if.sink           in_ch,
	nrb_out_if.source        out_ch
);
	logic [23:0] time_step_q;
	logic [16:0] beta_q, gamma_q;
	logic [31:0] mass_q, inertia_q;
	nrb_pkg::q16_t pos_q [3];
	nrb_pkg::q16_t vel_q [3];
	nrb_pkg::q16_t acc_q [3];
	nrb_pkg::q16_t val_q [3];
	nrb_pkg::seq_state_t state_q, state_d;
	logic        mode0_q;
	logic [1:0]  status_q;
	logic        out_valid_q;
	logic [47:0] pdt2_s1;
	logic signed [42:0] pkv_s1, pkq_s2;
	logic [40:0] pkg_s1, pkb_s2;
	nrb_pkg::coef_set_t coef_q;
	logic signed [17:0] bm, gm;
	logic signed [42:0] kv_adj, kq_adj;
	logic        bad;
	logic        in_fire, out_free, lane_start, sat_any;
	nrb_pkg::lane_stat_t stat [3];
	nrb_pkg::q16_t q_new [3];
	nrb_pkg::q16_t v_new [3];
	nrb_pkg::q16_t a_new [3];

	assign in_ch.ready = state_q == nrb_pkg::ST_IDLE;
	assign in_fire = in_ch.valid && in_ch.ready;
	assign out_free = !out_valid_q || out_ch.ready;
	assign lane_start = state_q == nrb_pkg::ST_COEF3;
	assign bm = 18'sd32768 - $signed({1'b0, beta_q});
	assign gm = 18'sd65536 - $signed({1'b0, gamma_q});
	assign kv_adj = pkv_s1 + (pkv_s1[42] ? 43'sd65535 : 43'sd0);
	assign kq_adj = pkq_s2 + (pkq_s2[42] ? 43'sd65535 : 43'sd0);
	assign bad = time_step_q == '0 || beta_q == '0 || gamma_q == '0
		|| (in_ch.mode == nrb_pkg::MODE_FORCE && (mass_q == '0 || inertia_q == '0));
	assign sat_any = stat[0].sat | stat[1].sat | stat[2].sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_step_q <= 24'd16777;
			beta_q      <= 17'd16384;
			gamma_q     <= 17'd32768;
			mass_q      <= 32'd65536;
			inertia_q   <= 32'd65536;
		end else if (cfg_we) begin
			unique case (cfg_index)
				nrb_pkg::REG_TIME_STEP:    time_step_q <= cfg_data[23:0];
				nrb_pkg::REG_BETA_COEFF:   beta_q <= cfg_data[16:0];
				nrb_pkg::REG_GAMMA_COEFF:  gamma_q <= cfg_data[16:0];
				nrb_pkg::REG_BODY_MASS:    mass_q <= cfg_data;
				nrb_pkg::REG_BODY_INERTIA: inertia_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			nrb_pkg::ST_IDLE: begin
				if (in_fire) begin
					if ((in_ch.mode == nrb_pkg::MODE_FORCE || in_ch.mode == nrb_pkg::MODE_ACCEL)
						&& !bad) state_d = nrb_pkg::ST_COEF1;
					else state_d = nrb_pkg::ST_FIN;
				end
			end
			nrb_pkg::ST_COEF1: state_d = nrb_pkg::ST_COEF2;
			nrb_pkg::ST_COEF2: state_d = nrb_pkg::ST_COEF3;
			nrb_pkg::ST_COEF3: state_d = nrb_pkg::ST_RUN;
			nrb_pkg::ST_RUN:   if (stat[0].done) state_d = nrb_pkg::ST_FIN;
			nrb_pkg::ST_FIN:   if (out_free) state_d = nrb_pkg::ST_IDLE;
			default:           state_d = nrb_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= nrb_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
			status_q    <= nrb_pkg::STATUS_OK;
			for (int i = 0; i < 3; i++) begin
				pos_q[i] <= '0;
				vel_q[i] <= '0;
				acc_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (state_q == nrb_pkg::ST_FIN && out_free) out_valid_q <= 1'b1;
			else if (out_ch.ready) out_valid_q <= 1'b0;
			if (in_fire) begin
				status_q <= nrb_pkg::STATUS_OK;
				case (in_ch.mode) inside
					nrb_pkg::MODE_FORCE, nrb_pkg::MODE_ACCEL: begin
						if (bad) status_q <= nrb_pkg::STATUS_INVALID;
					end
					nrb_pkg::MODE_LOAD_POS: begin
						pos_q[0] <= in_ch.value_x;
						pos_q[1] <= in_ch.value_y;
						pos_q[2] <= in_ch.value_rot;
					end
					nrb_pkg::MODE_LOAD_VEL: begin
						vel_q[0] <= in_ch.value_x;
						vel_q[1] <= in_ch.value_y;
						vel_q[2] <= in_ch.value_rot;
					end
					nrb_pkg::MODE_LOAD_ACC: begin
						acc_q[0] <= in_ch.value_x;
						acc_q[1] <= in_ch.value_y;
						acc_q[2] <= in_ch.value_rot;
					end
					default: begin
					end
				endcase
			end
			// Merge: all lanes finish together; any lane saturating marks the step.
			if (state_q == nrb_pkg::ST_RUN && stat[0].done) begin
				for (int i = 0; i < 3; i++) begin
					pos_q[i] <= q_new[i];
					vel_q[i] <= v_new[i];
					acc_q[i] <= a_new[i];
				end
				if (sat_any) status_q <= nrb_pkg::STATUS_SAT;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			mode0_q  <= in_ch.mode == nrb_pkg::MODE_FORCE;
			val_q[0] <= in_ch.value_x;
			val_q[1] <= in_ch.value_y;
			val_q[2] <= in_ch.value_rot;
		end
		case (state_q)
			nrb_pkg::ST_COEF1: begin
				pdt2_s1   <= 48'(time_step_q * time_step_q);
				pkv_s1    <= 43'($signed({1'b0, time_step_q}) * gm);
				pkg_s1    <= 41'(time_step_q * gamma_q);
				coef_q.dt <= time_step_q;
			end
			nrb_pkg::ST_COEF2: begin
				pkq_s2    <= 43'($signed({1'b0, pdt2_s1[47:24]}) * bm);
				pkb_s2    <= 41'(pdt2_s1[47:24] * beta_q);
				coef_q.kv <= nrb_pkg::coef_t'(kv_adj >>> 16);
				coef_q.kg <= $signed({2'b0, pkg_s1[40:16]});
			end
			nrb_pkg::ST_COEF3: begin
				coef_q.kq <= nrb_pkg::coef_t'(kq_adj >>> 16);
				coef_q.kb <= $signed({2'b0, pkb_s2[40:16]});
			end
			default: begin
			end
		endcase
	end

	for (genvar g = 0; g < 3; g++) begin : g_lane
		nrb_lane u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.start   (lane_start),
			.use_div (mode0_q),
			.coef    (coef_q),
			.den     ((g < 2) ? mass_q : inertia_q),
			.value   (val_q[g]),
			.q       (pos_q[g]),
			.v       (vel_q[g]),
			.a       (acc_q[g]),
			.stat    (stat[g]),
			.q_new   (q_new[g]),
			.v_new   (v_new[g]),
			.a_new   (a_new[g])
		);
	end

	always_ff @(posedge clk) begin
		if (state_q == nrb_pkg::ST_FIN && out_free) begin
			out_ch.position_x    <= pos_q[0];
			out_ch.position_y    <= pos_q[1];
			out_ch.angle         <= pos_q[2];
			out_ch.velocity_x    <= vel_q[0];
			out_ch.velocity_y    <= vel_q[1];
			out_ch.angular_rate  <= vel_q[2];
			out_ch.accel_x       <= acc_q[0];
			out_ch.accel_y       <= acc_q[1];
			out_ch.angular_accel <= acc_q[2];
			out_ch.status        <= status_q;
		end
	end
	assign out_ch.valid = out_valid_q;

	a_lanes_in_step: assert property (@(posedge clk) disable iff (!arst_n)
		stat[0].done == stat[1].done && stat[0].done == stat[2].done)
		else $error("lanes finished out of step");
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> state_q != nrb_pkg::ST_IDLE)
		else $error("sequencer idle right after a transfer");
	a_done_only_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		stat[0].done |-> state_q == nrb_pkg::ST_RUN)
		else $error("lane result outside the run phase");
endmodule
`default_nettype wire
